/* design/tms_pkg.sv */
package tms_pkg;

    localparam int MAX_EDGES_DEF  = 256;
    localparam int INDEX_BITS_DEF = 16;
    localparam int IDX_W          = 16;
    localparam int POS_W          = 32;
    localparam int KEY_W          = 32;
    localparam int QDEPTH         = 2;

    localparam logic REC_VERTEX   = 1'b0;
    localparam logic REC_TRIANGLE = 1'b1;

    localparam logic [0:0] REG_BASE = 1'b0;

    typedef struct packed {
        logic [IDX_W-1:0] corner0_index;
        logic [IDX_W-1:0] corner1_index;
        logic [IDX_W-1:0] corner2_index;
        logic signed [POS_W-1:0] corner0_x;
        logic signed [POS_W-1:0] corner0_y;
        logic signed [POS_W-1:0] corner0_z;
        logic signed [POS_W-1:0] corner1_x;
        logic signed [POS_W-1:0] corner1_y;
        logic signed [POS_W-1:0] corner1_z;
        logic signed [POS_W-1:0] corner2_x;
        logic signed [POS_W-1:0] corner2_y;
        logic signed [POS_W-1:0] corner2_z;
    } tri_in_t;

    typedef struct packed {
        logic record_kind;
        logic [IDX_W-1:0] new_vertex_index;
        logic signed [POS_W-1:0] mid_x;
        logic signed [POS_W-1:0] mid_y;
        logic signed [POS_W-1:0] mid_z;
        logic [IDX_W-1:0] tri_a;
        logic [IDX_W-1:0] tri_b;
        logic [IDX_W-1:0] tri_c;
        logic overflow;
        logic last;
    } rec_out_t;

    // classified triangle handed from front to back
    typedef struct packed {
        logic overflow;
        logic [2:0] fresh;
        logic [IDX_W-1:0] i0;
        logic [IDX_W-1:0] i1;
        logic [IDX_W-1:0] i2;
        logic [IDX_W-1:0] m0;
        logic [IDX_W-1:0] m1;
        logic [IDX_W-1:0] m2;
        logic signed [POS_W-1:0] h0x;
        logic signed [POS_W-1:0] h0y;
        logic signed [POS_W-1:0] h0z;
        logic signed [POS_W-1:0] h1x;
        logic signed [POS_W-1:0] h1y;
        logic signed [POS_W-1:0] h1z;
        logic signed [POS_W-1:0] h2x;
        logic signed [POS_W-1:0] h2y;
        logic signed [POS_W-1:0] h2z;
    } job_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SCAN,
        FS_WRITE
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MID,
        BS_TRI0,
        BS_TRI1,
        BS_TRI2,
        BS_TRI3
    } back_state_t;

    function automatic logic [POS_W-1:0] half_sum(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        begin
            s = {a[POS_W-1], a} + {b[POS_W-1], b};
            half_sum = s[POS_W:1];
        end
    endfunction

endpackage

/* design/tms_ram.sv */
module tms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/tms_front.sv */
module tms_front import tms_pkg::*; #(
    parameter int MAX_EDGES  = MAX_EDGES_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tri_in_t         item,
    output logic            busy,
    input  logic [IDX_W-1:0] base,
    output logic            job_valid,
    output job_t            job,
    input  logic            job_room
);

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);

    front_state_t state_reg, state_next;
    tri_in_t      item_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg;
    logic [2:0]    wr_reg;
    logic [2:0]    found_reg;
    logic [CW-1:0] slot_reg [3];
    logic          rd_valid_reg;
    logic [CW-1:0] rd_slot_reg;
    logic [KEY_W-1:0] rdata;
    logic [KEY_W-1:0] key [3];
    logic [2:0]    fresh;
    logic [1:0]    pend;
    logic [CW-1:0] mslot [3];
    logic          ovf;
    logic          scan_done;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [1:0]    wr_k;

    function automatic logic [KEY_W-1:0] mk(input logic [IDX_W-1:0] a,
                                            input logic [IDX_W-1:0] b);
        begin
            mk = (a < b) ? {a, b} : {b, a};
        end
    endfunction

    assign key[0] = mk(item_reg.corner0_index, item_reg.corner1_index);
    assign key[1] = mk(item_reg.corner1_index, item_reg.corner2_index);
    assign key[2] = mk(item_reg.corner2_index, item_reg.corner0_index);

    tms_ram #(.WIDTH(KEY_W), .DEPTH(MAX_EDGES)) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_reg[AW-1:0]),
        .rdata (rdata)
    );

    // dedupe within the triangle and assign slots
    always_comb
    begin
        logic [1:0] p;
        p = 2'd0;
        for (int j = 0; j < 3; j++)
        begin
            fresh[j] = 1'b0;
            mslot[j] = slot_reg[j];
        end
        // edge 0
        if (!found_reg[0])
        begin
            fresh[0] = 1'b1;
            mslot[0] = count_reg;
            p = 2'd1;
        end
        if (!found_reg[1])
        begin
            if (!found_reg[0] && key[1] == key[0])
            begin
                mslot[1] = count_reg;
            end
            else
            begin
                fresh[1] = 1'b1;
                mslot[1] = count_reg + CW'(p);
                p = p + 2'd1;
            end
        end
        if (!found_reg[2])
        begin
            if (!found_reg[0] && key[2] == key[0])
            begin
                mslot[2] = count_reg;
            end
            else if (!found_reg[1] && key[2] == key[1])
            begin
                mslot[2] = mslot[1];
            end
            else
            begin
                fresh[2] = 1'b1;
                mslot[2] = count_reg + CW'(p);
                p = p + 2'd1;
            end
        end
        pend = p;
    end

    always_comb
    begin
        logic [CW:0] need;
        logic [IDX_W+CW:0] top;
        need = {1'b0, count_reg} + (CW+1)'(pend);
        top  = (IDX_W+CW+1)'(base) + (IDX_W+CW+1)'(count_reg) + (IDX_W+CW+1)'(pend);
        ovf = (pend != 2'd0) &&
              ((need > (CW+1)'(MAX_EDGES)) ||
               (64'(top) > (64'd1 << INDEX_BITS)));
    end

    assign scan_done = rd_valid_reg ? 1'b0 : (scan_reg >= count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:  if (start) state_next = FS_SCAN;
            FS_SCAN:  if (!rd_valid_reg && scan_done && job_room) state_next =
                          (ovf || pend == 2'd0) ? FS_IDLE : FS_WRITE;
            FS_WRITE: if (wr_k == 2'd3) state_next = FS_IDLE;
            default:  state_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        wr_k = 2'd3;
        for (int j = 2; j >= 0; j--)
        begin
            if (fresh[j] && !wr_reg[j]) wr_k = 2'(j);
        end
    end

    always_comb
    begin
        busy      = (state_reg != FS_IDLE);
        job_valid = (state_reg == FS_SCAN) && !rd_valid_reg && scan_done && job_room;
        ram_we    = (state_reg == FS_WRITE) && (wr_k != 2'd3);
        ram_waddr = (wr_k == 2'd3) ? '0 : mslot[wr_k][AW-1:0];
        ram_wdata = (wr_k == 2'd3) ? '0 : key[wr_k];
    end

    assign count_next = count_reg + CW'(pend);

    always_comb
    begin
        job = '0;
        job.overflow = ovf;
        job.fresh = ovf ? 3'b000 : fresh;
        job.i0 = item_reg.corner0_index;
        job.i1 = item_reg.corner1_index;
        job.i2 = item_reg.corner2_index;
        job.m0 = IDX_W'((IDX_W+CW)'(base) + (IDX_W+CW)'(mslot[0]));
        job.m1 = IDX_W'((IDX_W+CW)'(base) + (IDX_W+CW)'(mslot[1]));
        job.m2 = IDX_W'((IDX_W+CW)'(base) + (IDX_W+CW)'(mslot[2]));
        job.h0x = half_sum(item_reg.corner0_x, item_reg.corner1_x);
        job.h0y = half_sum(item_reg.corner0_y, item_reg.corner1_y);
        job.h0z = half_sum(item_reg.corner0_z, item_reg.corner1_z);
        job.h1x = half_sum(item_reg.corner1_x, item_reg.corner2_x);
        job.h1y = half_sum(item_reg.corner1_y, item_reg.corner2_y);
        job.h1z = half_sum(item_reg.corner1_z, item_reg.corner2_z);
        job.h2x = half_sum(item_reg.corner2_x, item_reg.corner0_x);
        job.h2y = half_sum(item_reg.corner2_y, item_reg.corner0_y);
        job.h2z = half_sum(item_reg.corner2_z, item_reg.corner0_z);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FS_IDLE && start)
        begin
            item_reg <= item;
        end
        if (rd_valid_reg)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!found_reg[j] && rdata == key[j]) slot_reg[j] <= rd_slot_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FS_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            wr_reg       <= '0;
            found_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                FS_IDLE:
                begin
                    scan_reg     <= '0;
                    found_reg    <= '0;
                    wr_reg       <= '0;
                    rd_valid_reg <= 1'b0;
                end
                FS_SCAN:
                begin
                    rd_valid_reg <= !scan_done && !rd_valid_reg ? 1'b1 :
                                    (rd_valid_reg && scan_reg < count_reg);
                    rd_slot_reg  <= scan_reg;
                    if (scan_reg < count_reg) scan_reg <= scan_reg + CW'(1);
                    if (rd_valid_reg)
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            if (!found_reg[j] && rdata == key[j]) found_reg[j] <= 1'b1;
                        end
                    end
                end
                FS_WRITE:
                begin
                    // slots are taken from count_reg, so it moves only after the last key
                    if (wr_k != 2'd3) wr_reg[wr_k] <= 1'b1;
                    else count_reg <= count_next;
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_EDGES)) else $error("edge count beyond table");
    a_ovf_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && ovf |=> $stable(count_reg)) else $error("reject changed table");
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == FS_WRITE) else $error("stray table write");
`endif

endmodule

/* design/tms_back.sv */
module tms_back import tms_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    input  job_t     job,
    output logic     job_room,
    output logic     done,
    output rec_out_t result
);

    job_t        q_reg [QDEPTH];
    logic [0:0]  wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    back_state_t state_reg, state_next;
    job_t        cur_reg;
    logic [2:0]  left_reg;
    logic        pop;
    logic [1:0]  mk;
    rec_out_t    res_next;
    logic        done_next;

    assign job_room = (cnt_reg != 2'(QDEPTH));
    assign pop = (state_reg == BS_IDLE) && (cnt_reg != 2'd0);

    always_comb
    begin
        mk = 2'd3;
        for (int j = 2; j >= 0; j--)
        begin
            if (left_reg[j]) mk = 2'(j);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
                if (pop)
                begin
                    if (q_reg[rp_reg].overflow) state_next = BS_IDLE;
                    else if (q_reg[rp_reg].fresh != 3'b000) state_next = BS_MID;
                    else state_next = BS_TRI0;
                end
            BS_MID:  if ((left_reg & ~(3'b001 << mk)) == 3'b000) state_next = BS_TRI0;
            BS_TRI0: state_next = BS_TRI1;
            BS_TRI1: state_next = BS_TRI2;
            BS_TRI2: state_next = BS_TRI3;
            BS_TRI3: state_next = BS_IDLE;
            default: state_next = BS_IDLE;
        endcase
    end

    always_comb
    begin
        res_next  = '0;
        done_next = 1'b0;
        case (state_reg)
            BS_IDLE:
                if (pop && q_reg[rp_reg].overflow)
                begin
                    done_next = 1'b1;
                    res_next.record_kind = REC_TRIANGLE;
                    res_next.overflow = 1'b1;
                    res_next.last = 1'b1;
                end
            BS_MID:
            begin
                done_next = 1'b1;
                res_next.record_kind = REC_VERTEX;
                case (mk)
                    2'd0:
                    begin
                        res_next.new_vertex_index = cur_reg.m0;
                        res_next.mid_x = cur_reg.h0x;
                        res_next.mid_y = cur_reg.h0y;
                        res_next.mid_z = cur_reg.h0z;
                    end
                    2'd1:
                    begin
                        res_next.new_vertex_index = cur_reg.m1;
                        res_next.mid_x = cur_reg.h1x;
                        res_next.mid_y = cur_reg.h1y;
                        res_next.mid_z = cur_reg.h1z;
                    end
                    default:
                    begin
                        res_next.new_vertex_index = cur_reg.m2;
                        res_next.mid_x = cur_reg.h2x;
                        res_next.mid_y = cur_reg.h2y;
                        res_next.mid_z = cur_reg.h2z;
                    end
                endcase
            end
            BS_TRI0:
            begin
                done_next = 1'b1;
                res_next.record_kind = REC_TRIANGLE;
                res_next.tri_a = cur_reg.i0;
                res_next.tri_b = cur_reg.m0;
                res_next.tri_c = cur_reg.m2;
            end
            BS_TRI1:
            begin
                done_next = 1'b1;
                res_next.record_kind = REC_TRIANGLE;
                res_next.tri_a = cur_reg.i1;
                res_next.tri_b = cur_reg.m1;
                res_next.tri_c = cur_reg.m0;
            end
            BS_TRI2:
            begin
                done_next = 1'b1;
                res_next.record_kind = REC_TRIANGLE;
                res_next.tri_a = cur_reg.i2;
                res_next.tri_b = cur_reg.m2;
                res_next.tri_c = cur_reg.m1;
            end
            BS_TRI3:
            begin
                done_next = 1'b1;
                res_next.record_kind = REC_TRIANGLE;
                res_next.tri_a = cur_reg.m0;
                res_next.tri_b = cur_reg.m1;
                res_next.tri_c = cur_reg.m2;
                res_next.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_valid)
        begin
            q_reg[wp_reg] <= job;
        end
        if (pop)
        begin
            cur_reg <= q_reg[rp_reg];
        end
        result <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= done_next;
            if (job_valid) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(job_valid) - 2'(pop);
            if (pop) left_reg <= q_reg[rp_reg].fresh;
            else if (state_reg == BS_MID) left_reg <= left_reg & ~(3'b001 << mk);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> job_room) else $error("queue overrun");
    a_mid_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BS_MID |-> left_reg != 3'b000) else $error("empty midpoint step");
    a_tri_chain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BS_TRI0 |=> state_reg == BS_TRI1) else $error("triangle sequence broken");
`endif

endmodule

/* design/triangle_midpoint_subdivider.sv */
// Midpoint subdivider with an edge cache. Load a triangle with start while busy is low. Busy
// then stays high while the cached edges are scanned, longer while the two-entry queue is full,
// and while each new edge is written to the table. Results follow the end of the scan once the
// output side is idle and leave one per cycle on result_valid: up to three midpoint records and
// four triangle records, the last flagged by result.last; a rejected triangle gives one overflow
// record. The output side passes through idle between triangles. Results cannot be held off.
module triangle_midpoint_subdivider import tms_pkg::*; #(
    parameter int MAX_EDGES  = MAX_EDGES_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tri_in_t     item,
    output logic        result_valid,
    output rec_out_t    result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [IDX_W-1:0] base_reg;
    logic             job_valid;
    logic             job_room;
    job_t             job;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BASE) ? {16'd0, base_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_BASE)
        begin
            base_reg <= pwdata[IDX_W-1:0];
        end
    end

    tms_front #(.MAX_EDGES(MAX_EDGES), .INDEX_BITS(INDEX_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .base      (base_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_room  (job_room)
    );

    tms_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(job_valid),
        .job      (job),
        .job_room (job_room),
        .done     (result_valid),
        .result   (result)
    );

endmodule
